// ===== rtl/bfba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfba_pkg
// shared constants and types for the best-fit block allocator
// ----------------------------------------------------------------------------
package bfba_pkg;

  localparam int BLOCKS      = 16;
  localparam int IDX_W       = $clog2(BLOCKS);
  localparam int CNT_W       = $clog2(BLOCKS + 1);
  localparam int SIZE_W      = 16;
  localparam int STRIDE_W    = 16;
  localparam int ADDR_W      = 20;
  localparam int MODE_W      = 2;
  localparam int STAT_W      = 2;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 48;
  localparam int CFG_DATA_W  = 16;
  localparam int COUNT_REG_W = 5;

  localparam logic [COUNT_REG_W-1:0] COUNT_RESET  = COUNT_REG_W'(BLOCKS);
  localparam logic [STRIDE_W-1:0]    STRIDE_RESET = STRIDE_W'(100);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFIT  = 2'd1,
    STAT_BADIDX = 2'd2,
    STAT_ISFREE = 2'd3
  } status_t;

  typedef enum logic {
    CFG_COUNT  = 1'b0,
    CFG_STRIDE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_MUL    = 2'd2,
    S_RESULT = 2'd3
  } state_t;

endpackage

// ===== rtl/bfba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfba_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bfba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/best_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// best-fit allocator over a table of fixed partitions
// ----------------------------------------------------------------------------
// usage
//   s_* carries command beats: load a partition size, allocate the smallest
//   free partition that fits a request, or free a partition. m_* returns one
//   result beat per command: status, index, start address and size.
//   cfg_* writes block_count (index 0) and block_stride (index 1); write it
//   only while the block is idle.
// timing
//   one command at a time; s_tready is high only in the idle state.
//   load, free, reserved: the accepted command goes straight to the result state.
//   allocate: the scan reads one size table entry per cycle from the ram
//   through one shared compare unit, then the multiply state forms the
//   address and the result state follows.
// reset
//   synchronous; all partitions marked free, block_count 16, stride 100.
//   the size table is not cleared.
// stall
//   the result register holds its beat until m_tready; a finished result
//   waits in the result state while the register is still occupied.
// ----------------------------------------------------------------------------
module best_fit_block_allocator (
  input  logic                             clk,
  input  logic                             rst,
  // mode[1:0], block_index[5:2], block_size[21:6], request[37:22], zero pad
  input  logic [bfba_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // status[1:0], chosen_index[5:2], start_address[25:6], chosen_size[41:26]
  output logic [bfba_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [bfba_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bfba_pkg::state_t                  state;
  bfba_pkg::state_t                  state_next;

  logic [bfba_pkg::COUNT_REG_W-1:0]  block_count;
  logic [bfba_pkg::STRIDE_W-1:0]     block_stride;
  logic [bfba_pkg::BLOCKS-1:0]       free_marks;
  logic [bfba_pkg::CNT_W-1:0]        live_count;

  bfba_pkg::mode_t                   mode_q;
  logic [bfba_pkg::IDX_W-1:0]        idx_q;
  logic [bfba_pkg::SIZE_W-1:0]       size_q;
  logic [bfba_pkg::SIZE_W-1:0]       req_q;

  logic [bfba_pkg::CNT_W-1:0]        scan_ptr;
  logic                              cmp_valid;
  logic [bfba_pkg::IDX_W-1:0]        cmp_idx;
  logic                              found;
  logic [bfba_pkg::IDX_W-1:0]        best_idx;
  logic [bfba_pkg::SIZE_W-1:0]       best_size;
  logic [bfba_pkg::ADDR_W-1:0]       addr_q;

  logic                              in_accept;
  logic                              out_free;
  logic                              issue;
  logic                              hit;
  logic                              idx_ok;
  logic                              commit;
  logic                              ram_wr_en;
  logic [bfba_pkg::SIZE_W-1:0]       ram_rd_data;

  bfba_pkg::status_t                 res_status;
  logic [bfba_pkg::IDX_W-1:0]        res_idx;
  logic [bfba_pkg::ADDR_W-1:0]       res_addr;
  logic [bfba_pkg::SIZE_W-1:0]       res_size;

  // clamp the count to the table depth
  assign live_count = (block_count > bfba_pkg::COUNT_REG_W'(bfba_pkg::BLOCKS)) ?
                      bfba_pkg::CNT_W'(bfba_pkg::BLOCKS) :
                      bfba_pkg::CNT_W'(block_count);

  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign idx_ok    = {1'b0, idx_q} < live_count;
  assign commit    = (state == bfba_pkg::S_RESULT) && out_free;

  // shared compare unit
  assign hit = cmp_valid && free_marks[cmp_idx] && (ram_rd_data >= req_q) &&
               (!found || (ram_rd_data < best_size));

  bfba_ram #(
    .WIDTH (bfba_pkg::SIZE_W),
    .DEPTH (bfba_pkg::BLOCKS)
  ) u_size_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (idx_q),
    .wr_data (size_q),
    .rd_addr (scan_ptr[bfba_pkg::IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bfba_pkg::S_IDLE: begin
        if (in_accept) begin
          if (bfba_pkg::mode_t'(s_tdata[1:0]) == bfba_pkg::MODE_ALLOC) begin
            state_next = bfba_pkg::S_SCAN;
          end else begin
            state_next = bfba_pkg::S_RESULT;
          end
        end
      end
      bfba_pkg::S_SCAN: begin
        if (!(scan_ptr < live_count) && !cmp_valid) begin
          state_next = bfba_pkg::S_MUL;
        end
      end
      bfba_pkg::S_MUL: begin
        state_next = bfba_pkg::S_RESULT;
      end
      bfba_pkg::S_RESULT: begin
        if (out_free) begin
          state_next = bfba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bfba_pkg::S_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    s_tready  = (state == bfba_pkg::S_IDLE);
    issue     = (state == bfba_pkg::S_SCAN) && (scan_ptr < live_count);
    ram_wr_en = commit && (mode_q == bfba_pkg::MODE_LOAD) && idx_ok;
  end

  // result fields
  always_comb begin
    res_status = bfba_pkg::STAT_BADIDX;
    res_idx    = '0;
    res_addr   = '0;
    res_size   = '0;
    case (mode_q)
      bfba_pkg::MODE_LOAD: begin
        if (idx_ok) begin
          res_status = bfba_pkg::STAT_OK;
          res_idx    = idx_q;
        end
      end
      bfba_pkg::MODE_ALLOC: begin
        if (found) begin
          res_status = bfba_pkg::STAT_OK;
          res_idx    = best_idx;
          res_addr   = addr_q;
          res_size   = best_size;
        end else begin
          res_status = bfba_pkg::STAT_NOFIT;
        end
      end
      bfba_pkg::MODE_FREE: begin
        if (!idx_ok) begin
          res_status = bfba_pkg::STAT_BADIDX;
        end else if (free_marks[idx_q]) begin
          res_status = bfba_pkg::STAT_ISFREE;
        end else begin
          res_status = bfba_pkg::STAT_OK;
          res_idx    = idx_q;
        end
      end
      default: begin
        res_status = bfba_pkg::STAT_BADIDX;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bfba_pkg::S_IDLE;
      block_count  <= bfba_pkg::COUNT_RESET;
      block_stride <= bfba_pkg::STRIDE_RESET;
      free_marks   <= '1;
      cmp_valid    <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      if (cfg_valid && cfg_ready) begin
        if (bfba_pkg::cfg_reg_t'(cfg_index) == bfba_pkg::CFG_COUNT) begin
          block_count <= cfg_data[bfba_pkg::COUNT_REG_W-1:0];
        end else begin
          block_stride <= cfg_data;
        end
      end
      if (commit) begin
        m_tvalid <= 1'b1;
        case (mode_q)
          bfba_pkg::MODE_LOAD: begin
            if (idx_ok) begin
              free_marks[idx_q] <= 1'b1;
            end
          end
          bfba_pkg::MODE_ALLOC: begin
            if (found) begin
              free_marks[best_idx] <= 1'b0;
            end
          end
          bfba_pkg::MODE_FREE: begin
            if (idx_ok) begin
              free_marks[idx_q] <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_q   <= bfba_pkg::mode_t'(s_tdata[1:0]);
      idx_q    <= s_tdata[5:2];
      size_q   <= s_tdata[21:6];
      req_q    <= s_tdata[37:22];
      scan_ptr <= '0;
      found    <= 1'b0;
    end else if (issue) begin
      scan_ptr <= scan_ptr + bfba_pkg::CNT_W'(1);
    end
    cmp_idx <= scan_ptr[bfba_pkg::IDX_W-1:0];
    if (hit) begin
      found     <= 1'b1;
      best_idx  <= cmp_idx;
      best_size <= ram_rd_data;
    end
    if (state == bfba_pkg::S_MUL) begin
      addr_q <= bfba_pkg::ADDR_W'(best_idx) * bfba_pkg::ADDR_W'(block_stride);
    end
    if (commit) begin
      m_tdata <= {6'd0, res_size, res_addr, res_idx, res_status};
    end
  end

endmodule

// ===== test/bfba_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfba_response_checker
// Watches the command, result and register channels of the best-fit block
// allocator. Each accepted command goes through an internal partition table
// model, and the predicted response is queued. Each result beat is compared
// field by field with the oldest queued response.
// ----------------------------------------------------------------------------
module bfba_response_checker
  import bfba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_DATA_W-1:0]   s_tdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [OUT_DATA_W-1:0]  m_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding,
  output int                     beats_checked,
  output int                     grants,
  output int                     refusals
);

  typedef struct {
    status_t           status;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } response_t;

  logic [COUNT_REG_W-1:0] count_reg;
  logic [STRIDE_W-1:0]    stride_reg;
  logic [SIZE_W-1:0]      part_size [BLOCKS];
  logic [BLOCKS-1:0]      free_map;
  response_t              pending_responses [$];
  int                     err_total;
  int                     checked_total;
  int                     grant_total;
  int                     refusal_total;

  function automatic response_t serve_command(input mode_t mode,
                                              input logic [IDX_W-1:0] idx,
                                              input logic [SIZE_W-1:0] bsize,
                                              input logic [SIZE_W-1:0] req);
    response_t   r;
    int unsigned in_use;
    int          best;
    int          i;
    r = '{status: STAT_BADIDX, index: '0, addr: '0, size: '0};
    in_use = (count_reg > BLOCKS) ? BLOCKS : count_reg;
    best = -1;
    case (mode)
      MODE_LOAD: begin
        if (idx < in_use) begin
          part_size[idx] = bsize;
          free_map[idx] = 1'b1;
          r.status = STAT_OK;
          r.index = idx;
        end
      end
      MODE_ALLOC: begin
        for (i = 0; i < in_use; i++) begin
          if (free_map[i] && part_size[i] >= req &&
              (best < 0 || part_size[i] < part_size[best]))
            best = i;
        end
        if (best >= 0) begin
          free_map[best] = 1'b0;
          r.status = STAT_OK;
          r.index = best[IDX_W-1:0];
          r.addr = ADDR_W'(best * stride_reg);
          r.size = part_size[best];
          grant_total++;
        end else begin
          r.status = STAT_NOFIT;
          refusal_total++;
        end
      end
      MODE_FREE: begin
        if (idx >= in_use) begin
          r.status = STAT_BADIDX;
        end else if (free_map[idx]) begin
          r.status = STAT_ISFREE;
        end else begin
          free_map[idx] = 1'b1;
          r.status = STAT_OK;
          r.index = idx;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void report_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_total++;
    end
  endfunction

  always @(posedge clk) begin
    response_t want;
    response_t got;
    if (rst) begin
      count_reg = COUNT_RESET;
      stride_reg = STRIDE_RESET;
      free_map = '1;
      pending_responses.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COUNT)
          count_reg = cfg_data[COUNT_REG_W-1:0];
        else
          stride_reg = cfg_data[STRIDE_W-1:0];
      end
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tdata[1:0]);
        got.index = m_tdata[5:2];
        got.addr = m_tdata[25:6];
        got.size = m_tdata[41:26];
        checked_total++;
        if (pending_responses.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %0h", $time, m_tdata);
          err_total++;
        end else begin
          want = pending_responses.pop_front();
          report_field("status", 32'(want.status), 32'(got.status));
          report_field("chosen_index", 32'(want.index), 32'(got.index));
          report_field("start_address", 32'(want.addr), 32'(got.addr));
          report_field("chosen_size", 32'(want.size), 32'(got.size));
        end
      end
      if (s_tvalid && s_tready)
        pending_responses.push_back(serve_command(mode_t'(s_tdata[1:0]), s_tdata[5:2],
                                                  s_tdata[21:6], s_tdata[37:22]));
    end
    outstanding <= pending_responses.size();
    mismatches <= err_total;
    beats_checked <= checked_total;
    grants <= grant_total;
    refusals <= refusal_total;
  end

endmodule

// ===== test/tb_best_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_block_allocator
// Drives load, allocate, free and reserved commands into the allocator under
// several block count and stride settings, with random gaps on both streams
// and one long result stall. A checker beside the block predicts and compares
// every result beat; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_best_fit_block_allocator;
  import bfba_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int beats_checked;
  int grants;
  int refusals;

  int idle_cycles = 0;
  int commands_sent = 0;
  int settings_used = 0;
  int stall_budget = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  always #6 clk = ~clk;

  best_fit_block_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bfba_response_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tdata       (s_tdata),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .m_tdata       (m_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .beats_checked (beats_checked),
    .grants        (grants),
    .refusals      (refusals)
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random backpressure per beat, one long hold-off on request
  initial begin
    int gap;
    wait (!rst);
    forever begin
      if (stall_budget > 0) begin
        m_tready <= 1'b0;
        repeat (stall_budget) @(posedge clk);
        stall_budget = 0;
      end
      gap = rx_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // beat: mode[1:0], block_index[5:2], block_size[21:6], request[37:22], zero pad
  task automatic send_cmd(input mode_t mode, input logic [3:0] idx,
                          input logic [15:0] bsize, input logic [15:0] req);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {2'b00, req, bsize, idx, mode};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    commands_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] count_val, input logic [15:0] stride_val);
    drain();
    cfg_index <= CFG_COUNT;
    cfg_data <= count_val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_STRIDE;
    cfg_data <= stride_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_amount();
    case ($urandom_range(0, 4))
      1: return 16'(100 * $urandom_range(0, 10));
      2: return 16'($urandom_range(0, 2000));
      3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_command();
    int    pick;
    mode_t mode;
    pick = $urandom_range(0, 99);
    if (pick < 15)
      mode = MODE_LOAD;
    else if (pick < 55)
      mode = MODE_ALLOC;
    else if (pick < 92)
      mode = MODE_FREE;
    else
      mode = MODE_RSVD;
    send_cmd(mode, 4'($urandom_range(0, 15)), pick_amount(), pick_amount());
  endtask

  initial begin
    logic [15:0] init_sizes [16];
    int          p;
    init_sizes = '{16'hFFFF, 16'd0, 16'd500, 16'd300, 16'd500, 16'd1200, 16'd300,
                   16'hFFFE, 16'd1, 16'd800, 16'h8000, 16'd300, 16'd7, 16'd4000,
                   16'd2, 16'd999};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every partition gets a size before the first allocate
    for (p = 0; p < BLOCKS; p++)
      send_cmd(MODE_LOAD, 4'(p), init_sizes[p], 16'(p));

    // tie-breaking, extremes and status codes at reset settings
    send_cmd(MODE_ALLOC, 4'd9, 16'hABCD, 16'd0);
    send_cmd(MODE_ALLOC, 4'd0, 16'd0, 16'd300);
    send_cmd(MODE_ALLOC, 4'd0, 16'd0, 16'd300);
    send_cmd(MODE_ALLOC, 4'd0, 16'd0, 16'hFFFF);
    send_cmd(MODE_ALLOC, 4'd0, 16'd0, 16'hFFFF);
    send_cmd(MODE_FREE, 4'd3, 16'd0, 16'd0);
    send_cmd(MODE_FREE, 4'd3, 16'd0, 16'd0);
    send_cmd(MODE_FREE, 4'd15, 16'd0, 16'd0);
    send_cmd(MODE_RSVD, 4'd5, 16'hFFFF, 16'hFFFF);
    send_cmd(MODE_ALLOC, 4'd15, 16'hFFFF, 16'd1);

    // short table, widest stride
    configure(16'd4, 16'hFFFF);
    send_cmd(MODE_LOAD, 4'd9, 16'd50, 16'd0);
    send_cmd(MODE_FREE, 4'd12, 16'd0, 16'd0);
    send_cmd(MODE_ALLOC, 4'd0, 16'd0, 16'd0);
    send_cmd(MODE_ALLOC, 4'd0, 16'd0, 16'd0);
    send_cmd(MODE_ALLOC, 4'd0, 16'd0, 16'd0);
    send_cmd(MODE_LOAD, 4'd0, 16'd40000, 16'd0);

    // empty table
    configure(16'd0, 16'd0);
    send_cmd(MODE_ALLOC, 4'd0, 16'd0, 16'd0);
    send_cmd(MODE_LOAD, 4'd0, 16'd10, 16'd0);
    send_cmd(MODE_FREE, 4'd0, 16'd0, 16'd0);

    // count above the partition total acts as the full table
    configure(16'd31, 16'd1);
    send_cmd(MODE_ALLOC, 4'd0, 16'd0, 16'hFFFF);
    send_cmd(MODE_LOAD, 4'd15, 16'hFFFF, 16'd0);
    send_cmd(MODE_ALLOC, 4'd0, 16'd0, 16'hFFFF);
    send_cmd(MODE_FREE, 4'd15, 16'd0, 16'd0);

    for (p = 0; p < 6; p++) begin
      case (p)
        0: configure(16'd16, 16'd100);
        1: configure(16'd9, 16'hFFFF);
        2: configure(16'd1, 16'd0);
        3: configure(16'd0, 16'($urandom_range(0, 65535)));
        4: configure(16'd23, 16'd1);
        default: configure(16'd16, 16'($urandom_range(0, 65535)));
      endcase
      tx_steady = (p == 5);
      rx_steady = (p == 5);
      if (p == 4)
        stall_budget = 300;
      repeat ((p == 3) ? 80 : 270) random_command();
    end

    drain();
    repeat (30) @(posedge clk);
    $display("Summary: %0d commands over %0d register settings, %0d result beats checked",
             commands_sent, settings_used + 1, beats_checked);
    $display("Summary: %0d allocations granted, %0d refused for lack of a fitting block",
             grants, refusals);
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
